[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// SPS parser package
// Syntax step codes, field widths, status codes and the queue item type.
// ----------------------------------------------------------------------------
package sps_pkg;

    typedef enum logic [4:0] {
        ST_NAL_HDR, ST_PROFILE, ST_CONSTR_LEVEL, ST_SPS_ID, ST_CHROMA, ST_SEP_PLANE,
        ST_BD_LUMA, ST_BD_CHROMA, ST_BYPASS, ST_SCAL_PRESENT, ST_LIST_FLAG,
        ST_LIST_DELTA, ST_LOG2_FN, ST_POC_TYPE, ST_POC_LSB, ST_DELTA_ZERO,
        ST_OFF_NONREF, ST_OFF_T2B, ST_CYCLE_LEN, ST_CYCLE_OFF, ST_NUM_REF,
        ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT8,
        ST_CROP_FLAG, ST_CROP, ST_DONE, ST_ERROR
    } t_step;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_PREFIX    = 2'd2;
    localparam logic [1:0] STATUS_RANGE     = 2'd3;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // Width of each fixed field; zero marks an Exp-Golomb code.
    function automatic logic [4:0] field_bits(input t_step s);
        case (s)
            ST_NAL_HDR, ST_PROFILE:                      field_bits = 5'd8;
            ST_CONSTR_LEVEL:                             field_bits = 5'd16;
            ST_SEP_PLANE, ST_BYPASS, ST_SCAL_PRESENT,
            ST_LIST_FLAG, ST_DELTA_ZERO, ST_GAPS,
            ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT8,
            ST_CROP_FLAG:                                field_bits = 5'd1;
            default:                                     field_bits = 5'd0;
        endcase
    endfunction

endpackage

[rtl/h264_sps_dimension_parser_top.sv]
// ----------------------------------------------------------------------------
// H.264 SPS dimension parser
// Parses an SPS NAL unit and reports the cropped picture size.
// ----------------------------------------------------------------------------
//  Channel | Direction | Content
//  s_axis  | in        | one NAL byte per transaction, tlast on the final byte
//  m_axis  | out       | width, height and status, one per NAL unit
//
// The syntax engine consumes one bit per cycle while a byte is queued and no result
// is pending. After the final byte, multiply and subtract steps compute the result.
// A four-entry byte queue keeps the input open while the engine works or
// the result waits. Reset (synchronous, active low) empties both parts.
module h264_sps_dimension_parser_top import sps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [15:0] width, [31:16] height, [33:32] status
);
    logic  w_full, w_empty, w_pop, w_push;
    t_item w_in, w_head;
    logic [15:0] w_w, w_h;
    logic [1:0]  w_st;

    assign s_axis_tready = !w_full;
    assign w_push = s_axis_tvalid && !w_full;
    assign w_in.data_byte = s_axis_tdata;
    assign w_in.last_byte = s_axis_tlast;
    assign m_axis_tdata = {6'd0, w_st, w_h, w_w};

    sps_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(w_in),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_item(w_head)
    );

    sps_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_item(w_head),
        .o_pop(w_pop), .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_width(w_w), .o_height(w_h), .o_status(w_st)
    );
endmodule

[rtl/sps_queue.sv]
// ----------------------------------------------------------------------------
// SPS byte queue
// Small FIFO between the byte front end and the bit-serial syntax engine.
// ----------------------------------------------------------------------------
module sps_queue import sps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    t_item              r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wp, r_rp;
    logic [QueueAw:0]   r_cnt;

    assign o_full  = (r_cnt == (QueueAw+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueueAw+1)'(i_push) - (QueueAw+1)'(i_pop);
        end
    end
endmodule

[rtl/sps_engine.sv]
// ----------------------------------------------------------------------------
// SPS syntax engine
// Walks the SPS syntax one bit per cycle while a byte is queued; after
// the last byte it multiplies and subtracts for the cropped picture size.
// ----------------------------------------------------------------------------
module sps_engine import sps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [15:0] o_width,
    output logic [15:0] o_height,
    output logic [1:0]  o_status
);
    typedef enum logic [2:0] {PH_BITS, PH_MUL, PH_SUB, PH_OUT} t_phase;

    t_phase      r_ph;
    logic [2:0]  r_bit;
    t_step       r_step;
    logic [4:0]  r_left;
    logic [5:0]  r_pz;
    logic [31:0] r_suf;
    logic        r_insuf;
    logic [7:0]  r_prof;
    logic        r_444;
    logic [3:0]  r_list;
    logic [6:0]  r_entry;
    logic [7:0]  r_prior;
    logic [31:0] r_cyc;
    logic [31:0] r_wm, r_hu;
    logic        r_fo;
    logic [31:0] r_crop [4];
    logic        r_err;
    logic [36:0] r_wb, r_hb;
    logic [35:0] r_wc, r_hc;
    logic [15:0] r_w, r_h;
    logic [1:0]  r_st;

    logic        w_bit;
    logic        w_fin;
    logic [31:0] w_v;
    logic [31:0] w_sufn;
    logic [7:0]  w_coming;
    logic [7:0]  w_delta;
    logic [6:0]  w_ent1;
    logic [3:0]  w_l1;
    t_step       w_nextlist;
    t_step       w_nx;
    logic        w_active;
    logic [37:0] w_wd, w_hd;
    logic [15:0] w_wsat, w_hsat;
    logic        w_ov;

    assign w_bit = i_item.data_byte[r_bit];
    assign w_sufn = {r_suf[30:0], w_bit};
    assign w_active = (r_ph == PH_BITS) && !i_empty;
    assign o_pop = w_active && (r_bit == 3'd0);

    always_comb begin
        w_fin = 1'b0;
        w_v = w_sufn;
        if (r_step < ST_DONE) begin
            if (field_bits(r_step) != 5'd0 || r_insuf) begin
                if (r_left == 5'd1) w_fin = 1'b1;
                if (r_insuf) w_v = w_sufn + ((32'd1 << r_pz) - 32'd1);
            end else if (w_bit && r_pz == 6'd0) begin
                w_fin = 1'b1;
                w_v = '0;
            end
        end
        w_delta = w_v[0] ? 8'(w_v[8:1] + 8'd1) : 8'(8'd0 - w_v[8:1]);
        w_coming = r_prior + w_delta;
        w_ent1 = r_entry + 7'd1;
        w_l1 = r_list + 4'd1;
        w_nextlist = (w_l1 >= (r_444 ? 4'd12 : 4'd8)) ? ST_LOG2_FN : ST_LIST_FLAG;
        case (r_step)
            ST_NAL_HDR:      w_nx = ST_PROFILE;
            ST_PROFILE:      w_nx = ST_CONSTR_LEVEL;
            ST_CONSTR_LEVEL: w_nx = ST_SPS_ID;
            ST_SPS_ID: begin
                if (r_prof inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44,
                                   8'd83, 8'd86, 8'd118, 8'd128})
                    w_nx = ST_CHROMA;
                else
                    w_nx = ST_LOG2_FN;
            end
            ST_CHROMA:       w_nx = (w_v == 32'd3) ? ST_SEP_PLANE : ST_BD_LUMA;
            ST_SEP_PLANE:    w_nx = ST_BD_LUMA;
            ST_BD_LUMA:      w_nx = ST_BD_CHROMA;
            ST_BD_CHROMA:    w_nx = ST_BYPASS;
            ST_BYPASS:       w_nx = ST_SCAL_PRESENT;
            ST_SCAL_PRESENT: w_nx = (w_v != 0) ? ST_LIST_FLAG : ST_LOG2_FN;
            ST_LIST_FLAG:    w_nx = (w_v != 0) ? ST_LIST_DELTA : w_nextlist;
            ST_LIST_DELTA: begin
                if (w_coming == 8'd0 ||
                    w_ent1 >= ((r_list < 4'd6) ? 7'd16 : 7'd64))
                    w_nx = w_nextlist;
                else
                    w_nx = ST_LIST_DELTA;
            end
            ST_LOG2_FN: w_nx = ST_POC_TYPE;
            ST_POC_TYPE: begin
                if (w_v == 0)      w_nx = ST_POC_LSB;
                else if (w_v == 1) w_nx = ST_DELTA_ZERO;
                else               w_nx = ST_NUM_REF;
            end
            ST_POC_LSB:    w_nx = ST_NUM_REF;
            ST_DELTA_ZERO: w_nx = ST_OFF_NONREF;
            ST_OFF_NONREF: w_nx = ST_OFF_T2B;
            ST_OFF_T2B:    w_nx = ST_CYCLE_LEN;
            ST_CYCLE_LEN:  w_nx = (w_v != 0) ? ST_CYCLE_OFF : ST_NUM_REF;
            ST_CYCLE_OFF:  w_nx = (r_cyc != 32'd1) ? ST_CYCLE_OFF : ST_NUM_REF;
            ST_NUM_REF:    w_nx = ST_GAPS;
            ST_GAPS:       w_nx = ST_WIDTH;
            ST_WIDTH:      w_nx = ST_HEIGHT;
            ST_HEIGHT:     w_nx = ST_FRAME_ONLY;
            ST_FRAME_ONLY: w_nx = w_v[0] ? ST_DIRECT8 : ST_MBAFF;
            ST_MBAFF:      w_nx = ST_DIRECT8;
            ST_DIRECT8:    w_nx = ST_CROP_FLAG;
            ST_CROP_FLAG:  w_nx = (w_v != 0) ? ST_CROP : ST_DONE;
            ST_CROP:       w_nx = (r_list >= 4'd3) ? ST_DONE : ST_CROP;
            default:       w_nx = r_step;
        endcase
        w_wd = {1'b0, r_wb} - {2'b0, r_wc};
        w_hd = {1'b0, r_hb} - {2'b0, r_hc};
        w_ov = 1'b0;
        if (w_wd[37]) begin
            w_wsat = 16'd0; w_ov = 1'b1;
        end else if (w_wd[36:16] != 0) begin
            w_wsat = 16'hFFFF; w_ov = 1'b1;
        end else w_wsat = w_wd[15:0];
        if (w_hd[37]) begin
            w_hsat = 16'd0; w_ov = 1'b1;
        end else if (w_hd[36:16] != 0) begin
            w_hsat = 16'hFFFF; w_ov = 1'b1;
        end else w_hsat = w_hd[15:0];
    end

    assign o_res_valid = (r_ph == PH_OUT);
    assign o_width  = r_w;
    assign o_height = r_h;
    assign o_status = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_BITS;
            r_bit <= 3'd7;
            r_step <= ST_NAL_HDR;
            r_left <= 5'd8;
            r_pz <= '0;
            r_suf <= '0;
            r_insuf <= 1'b0;
            r_prof <= '0;
            r_444 <= 1'b0;
            r_list <= '0;
            r_entry <= '0;
            r_prior <= 8'd8;
            r_cyc <= '0;
            r_wm <= '0;
            r_hu <= '0;
            r_fo <= 1'b0;
            r_err <= 1'b0;
            for (int k = 0; k < 4; k++) r_crop[k] <= '0;
        end else begin
            case (r_ph)
                PH_BITS: if (w_active) begin
                    r_bit <= r_bit - 3'd1;
                    if (w_fin) begin
                        r_step <= w_nx;
                        r_left <= field_bits(w_nx);
                        r_pz <= '0;
                        r_suf <= '0;
                        r_insuf <= 1'b0;
                        case (r_step)
                            ST_PROFILE:      r_prof <= w_v[7:0];
                            ST_CHROMA:       r_444 <= (w_v == 32'd3);
                            ST_SCAL_PRESENT: r_list <= '0;
                            ST_LIST_FLAG: begin
                                if (w_v != 0) begin
                                    r_entry <= '0;
                                    r_prior <= 8'd8;
                                end else begin
                                    r_list <= w_l1;
                                end
                            end
                            ST_LIST_DELTA: begin
                                if (w_coming != 8'd0) r_prior <= w_coming;
                                r_entry <= w_ent1;
                                if (w_nx != ST_LIST_DELTA) r_list <= w_l1;
                            end
                            ST_CYCLE_LEN: r_cyc <= w_v;
                            ST_CYCLE_OFF: r_cyc <= r_cyc - 32'd1;
                            ST_WIDTH:     r_wm <= w_v;
                            ST_HEIGHT:    r_hu <= w_v;
                            ST_FRAME_ONLY: r_fo <= w_v[0];
                            ST_CROP_FLAG: r_list <= '0;
                            ST_CROP: begin
                                r_crop[r_list[1:0]] <= w_v;
                                r_list <= w_l1;
                            end
                            default: ;
                        endcase
                    end else if (r_step < ST_DONE) begin
                        if (field_bits(r_step) != 5'd0 || r_insuf) begin
                            r_suf <= w_sufn;
                            r_left <= r_left - 5'd1;
                        end else if (!w_bit) begin
                            r_pz <= r_pz + 6'd1;
                            if (r_pz == 6'd31) begin
                                r_err <= 1'b1;
                                r_step <= ST_ERROR;
                            end
                        end else begin
                            r_insuf <= 1'b1;
                            r_left <= r_pz[4:0];
                        end
                    end
                    if (r_bit == 3'd0 && i_item.last_byte) r_ph <= PH_MUL;
                end
                PH_MUL: begin
                    // The syntax state is final here; stage the products.
                    r_wb <= {1'b0, r_wm, 4'b0} + 37'd16;
                    r_hb <= r_fo ? ({1'b0, r_hu, 4'b0} + 37'd16)
                                 : ({r_hu, 5'b0} + 37'd32);
                    r_wc <= {3'b0, r_crop[0]} + {3'b0, r_crop[1]} << 1;
                    r_hc <= r_fo ? (({3'b0, r_crop[2]} + {3'b0, r_crop[3]}) << 1)
                                 : (({3'b0, r_crop[2]} + {3'b0, r_crop[3]}) << 2);
                    r_ph <= PH_SUB;
                end
                PH_SUB: begin
                    if (r_err) begin
                        r_st <= STATUS_PREFIX; r_w <= '0; r_h <= '0;
                    end else if (r_step != ST_DONE) begin
                        r_st <= STATUS_TRUNCATED; r_w <= '0; r_h <= '0;
                    end else begin
                        r_st <= w_ov ? STATUS_RANGE : STATUS_OK;
                        r_w <= w_wsat;
                        r_h <= w_hsat;
                    end
                    r_ph <= PH_OUT;
                end
                PH_OUT: if (i_res_ready) begin
                    r_ph <= PH_BITS;
                    r_bit <= 3'd7;
                    r_step <= ST_NAL_HDR;
                    r_left <= 5'd8;
                    r_pz <= '0;
                    r_suf <= '0;
                    r_insuf <= 1'b0;
                    r_prof <= '0;
                    r_444 <= 1'b0;
                    r_list <= '0;
                    r_entry <= '0;
                    r_prior <= 8'd8;
                    r_cyc <= '0;
                    r_wm <= '0;
                    r_hu <= '0;
                    r_fo <= 1'b0;
                    r_err <= 1'b0;
                    for (int k = 0; k < 4; k++) r_crop[k] <= '0;
                end
                default: r_ph <= PH_BITS;
            endcase
        end
    end
endmodule

[bench/h264_sps_dimension_parser_top_test.sv]
// ----------------------------------------------------------------------------
// SPS dimension parser testbench
// Streams SPS NAL units byte by byte into the parser: a short table of
// directed units first, then randomly built parameter sets with random
// content, truncations, long Golomb prefixes and trailing bytes. A bit-serial
// syntax walker in the bench predicts width, height and status for each unit.
// ----------------------------------------------------------------------------
module h264_sps_dimension_parser_top_test;
    import sps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  status;
    } t_dims;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          typed;
        t_dims       dims;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [15:0] width, [31:16] height, [33:32] status

    h264_sps_dimension_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_dims pending_dims[$];
    int    n_errors = 0;
    bit    quiet = 0;
    bit    row_typed = 0;
    t_dims row_dims;

    // ------------------------------------------------------------------------
    // Syntax walker
    // ------------------------------------------------------------------------
    t_step       w_step;
    logic [5:0]  w_left, w_zeros;
    logic [31:0] w_acc;
    bit          w_in_suffix;
    logic [7:0]  w_profile;
    bit          w_444;
    logic [3:0]  w_list;
    logic [6:0]  w_entry;
    logic [7:0]  w_prior, w_coming;
    logic [31:0] w_cycles, w_width_m1, w_height_m1;
    bit          w_frames_only, w_prefix_err;
    logic [31:0] w_crop[4];

    function automatic logic [5:0] fixed_width(t_step s);
        case (s)
            ST_NAL_HDR, ST_PROFILE: return 6'd8;
            ST_CONSTR_LEVEL: return 6'd16;
            ST_SEP_PLANE, ST_BYPASS, ST_SCAL_PRESENT, ST_LIST_FLAG, ST_DELTA_ZERO,
            ST_GAPS, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT8, ST_CROP_FLAG: return 6'd1;
            default: return 6'd0;
        endcase
    endfunction

    task automatic go_to(t_step s);
        w_step = s;
        w_left = fixed_width(s);
        w_zeros = 0;
        w_acc = 0;
        w_in_suffix = 0;
    endtask

    task automatic walker_reset();
        go_to(ST_NAL_HDR);
        w_profile = 0; w_444 = 0; w_list = 0; w_entry = 0;
        w_prior = 8; w_coming = 8;
        w_cycles = 0; w_width_m1 = 0; w_height_m1 = 0;
        w_frames_only = 0; w_prefix_err = 0;
        for (int k = 0; k < 4; k++) w_crop[k] = 0;
    endtask

    task automatic advance_list();
        w_list = w_list + 1;
        if (w_list >= (w_444 ? 12 : 8)) go_to(ST_LOG2_FN);
        else go_to(ST_LIST_FLAG);
    endtask

    task automatic close_field(logic [31:0] v);
        logic [31:0] delta;
        case (w_step)
            ST_NAL_HDR: go_to(ST_PROFILE);
            ST_PROFILE: begin
                w_profile = v[7:0];
                go_to(ST_CONSTR_LEVEL);
            end
            ST_CONSTR_LEVEL: go_to(ST_SPS_ID);
            ST_SPS_ID: begin
                case (w_profile)
                    8'd100, 8'd110, 8'd122, 8'd244, 8'd44,
                    8'd83, 8'd86, 8'd118, 8'd128: go_to(ST_CHROMA);
                    default: go_to(ST_LOG2_FN);
                endcase
            end
            ST_CHROMA: begin
                w_444 = (v == 3);
                go_to(w_444 ? ST_SEP_PLANE : ST_BD_LUMA);
            end
            ST_SEP_PLANE: go_to(ST_BD_LUMA);
            ST_BD_LUMA: go_to(ST_BD_CHROMA);
            ST_BD_CHROMA: go_to(ST_BYPASS);
            ST_BYPASS: go_to(ST_SCAL_PRESENT);
            ST_SCAL_PRESENT: begin
                w_list = 0;
                go_to(v != 0 ? ST_LIST_FLAG : ST_LOG2_FN);
            end
            ST_LIST_FLAG: begin
                if (v != 0) begin
                    w_entry = 0; w_prior = 8; w_coming = 8;
                    go_to(ST_LIST_DELTA);
                end else begin
                    advance_list();
                end
            end
            ST_LIST_DELTA: begin
                delta = v[0] ? (v >> 1) + 1 : 32'd0 - (v >> 1);
                w_coming = w_prior + delta[7:0];
                if (w_coming != 0) w_prior = w_coming;
                w_entry = w_entry + 1;
                if (w_coming == 0 || w_entry >= (w_list < 6 ? 16 : 64)) advance_list();
                else go_to(ST_LIST_DELTA);
            end
            ST_LOG2_FN: go_to(ST_POC_TYPE);
            ST_POC_TYPE: go_to(v == 0 ? ST_POC_LSB : v == 1 ? ST_DELTA_ZERO : ST_NUM_REF);
            ST_POC_LSB: go_to(ST_NUM_REF);
            ST_DELTA_ZERO: go_to(ST_OFF_NONREF);
            ST_OFF_NONREF: go_to(ST_OFF_T2B);
            ST_OFF_T2B: go_to(ST_CYCLE_LEN);
            ST_CYCLE_LEN: begin
                w_cycles = v;
                go_to(v != 0 ? ST_CYCLE_OFF : ST_NUM_REF);
            end
            ST_CYCLE_OFF: begin
                w_cycles = w_cycles - 1;
                go_to(w_cycles != 0 ? ST_CYCLE_OFF : ST_NUM_REF);
            end
            ST_NUM_REF: go_to(ST_GAPS);
            ST_GAPS: go_to(ST_WIDTH);
            ST_WIDTH: begin
                w_width_m1 = v;
                go_to(ST_HEIGHT);
            end
            ST_HEIGHT: begin
                w_height_m1 = v;
                go_to(ST_FRAME_ONLY);
            end
            ST_FRAME_ONLY: begin
                w_frames_only = v[0];
                go_to(w_frames_only ? ST_DIRECT8 : ST_MBAFF);
            end
            ST_MBAFF: go_to(ST_DIRECT8);
            ST_DIRECT8: go_to(ST_CROP_FLAG);
            ST_CROP_FLAG: begin
                w_list = 0;
                go_to(v != 0 ? ST_CROP : ST_DONE);
            end
            ST_CROP: begin
                w_crop[w_list[1:0]] = v;
                w_list = w_list + 1;
                go_to(w_list >= 4 ? ST_DONE : ST_CROP);
            end
            default: ;
        endcase
    endtask

    task automatic feed_bit(bit b);
        logic [31:0] v;
        if (w_step == ST_DONE || w_step == ST_ERROR) return;
        if (fixed_width(w_step) != 0 || w_in_suffix) begin
            w_acc = {w_acc[30:0], b};
            w_left = w_left - 1;
            if (w_left == 0) begin
                v = w_acc;
                if (w_in_suffix) v = v + ((32'd1 << w_zeros) - 1);
                close_field(v);
            end
        end else if (!b) begin
            w_zeros = w_zeros + 1;
            if (w_zeros > 31) begin
                w_prefix_err = 1;
                w_step = ST_ERROR;
            end
        end else if (w_zeros == 0) begin
            close_field(0);
        end else begin
            w_in_suffix = 1;
            w_left = w_zeros;
        end
    endtask

    // Cropped size, saturated at both ends of the 16-bit range.
    function automatic logic [15:0] crop_dim(logic [63:0] full, logic [63:0] cut,
                                             ref bit bad);
        if (cut > full) begin
            bad = 1;
            return 16'd0;
        end
        if (full - cut > 64'd65535) begin
            bad = 1;
            return 16'hFFFF;
        end
        return 16'(full - cut);
    endfunction

    task automatic predict_byte(logic [7:0] data, logic last);
        t_dims d;
        bit bad;
        logic [63:0] wf, wc, hf, hc;
        for (int k = 7; k >= 0; k--) feed_bit(data[k]);
        if (!last) return;
        d = '{16'd0, 16'd0, STATUS_OK};
        if (w_prefix_err) begin
            d.status = STATUS_PREFIX;
        end else if (w_step != ST_DONE) begin
            d.status = STATUS_TRUNCATED;
        end else begin
            bad = 0;
            wf = (64'(w_width_m1) + 1) * 16;
            wc = 2 * (64'(w_crop[0]) + w_crop[1]);
            hf = (w_frames_only ? 64'd1 : 64'd2) * (64'(w_height_m1) + 1) * 16;
            hc = (w_frames_only ? 64'd2 : 64'd4) * (64'(w_crop[2]) + w_crop[3]);
            d.width = crop_dim(wf, wc, bad);
            d.height = crop_dim(hf, hc, bad);
            d.status = bad ? STATUS_RANGE : STATUS_OK;
        end
        pending_dims.push_back(d);
        walker_reset();
    endtask

    // ------------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dims want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dims.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_dims.pop_front();
                if (m_axis_tdata[15:0] !== want.width) begin
                    $display("%0t: width expected %0d actual %0d",
                             $time, want.width, m_axis_tdata[15:0]);
                    n_errors++;
                end
                if (m_axis_tdata[31:16] !== want.height) begin
                    $display("%0t: height expected %0d actual %0d",
                             $time, want.height, m_axis_tdata[31:16]);
                    n_errors++;
                end
                if (m_axis_tdata[33:32] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[33:32]);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_byte(s_axis_tdata, s_axis_tlast);
            // Directed rows with a hand-written result replace the prediction.
            if (s_axis_tlast && row_typed) begin
                void'(pending_dims.pop_back());
                pending_dims.push_back(row_dims);
            end
        end
    end

    // Result side stalls in random bursts.
    int sink_hold = 0;
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(1, 19);
        end
        m_axis_tready <= i_rst_n && (sink_hold == 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    bit sps_bits[$];
    int bytes_sent = 0;

    task automatic put_bits(longint unsigned v, int n);
        for (int k = n - 1; k >= 0; k--) sps_bits.push_back(v[k]);
    endtask

    task automatic put_ue(longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> n) != 0) n++;
        put_bits(0, n - 1);
        put_bits(x, n);
    endtask

    task automatic put_se(int d);
        if (d > 0) put_ue(2 * longint'(d) - 1);
        else put_ue(-2 * longint'(d));
    endtask

    function automatic longint unsigned pick_size();
        if ($urandom_range(0, 15) == 0) return longint'($urandom_range(0, 32'hFFFF_FFFE));
        return $urandom_range(0, 120);
    endfunction

    function automatic longint unsigned pick_crop();
        if ($urandom_range(0, 11) == 0) return longint'($urandom_range(0, 32'hFFFF_FFFE));
        return $urandom_range(0, 8);
    endfunction

    // Drives one byte; the caller is at a falling edge, and so is the return.
    task automatic send_byte(logic [7:0] data, logic last, bit typed, t_dims dims);
        row_typed = typed;
        row_dims = dims;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic build_sps();
        logic [7:0] prof;
        int chroma, poc, n_lists, cyc;
        logic [7:0] prior, nxt;
        int d;
        sps_bits.delete();
        put_bits(8'h67, 8);
        case ($urandom_range(0, 3))
            0: prof = $urandom_range(0, 255);
            1: prof = 8'd66;
            default: begin
                case ($urandom_range(0, 8))
                    0: prof = 100; 1: prof = 110; 2: prof = 122;
                    3: prof = 244; 4: prof = 44;  5: prof = 83;
                    6: prof = 86;  7: prof = 118; default: prof = 128;
                endcase
            end
        endcase
        put_bits(prof, 8);
        put_bits($urandom_range(0, 16'hFFFF), 16);
        if ($urandom_range(0, 19) == 0) begin
            // Golomb prefix longer than the parser allows.
            put_bits(0, $urandom_range(32, 40));
            put_bits($urandom, 16);
        end else begin
            put_ue($urandom_range(0, 31));
            if (prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128}) begin
                chroma = $urandom_range(0, 4);
                put_ue(chroma);
                if (chroma == 3) put_bits($urandom_range(0, 1), 1);
                put_ue($urandom_range(0, 6));
                put_ue($urandom_range(0, 6));
                put_bits($urandom_range(0, 1), 1);
                if ($urandom_range(0, 3) == 0) begin
                    put_bits(1, 1);
                    n_lists = (chroma == 3) ? 12 : 8;
                    for (int l = 0; l < n_lists; l++) begin
                        if ($urandom_range(0, 2) == 0) begin
                            put_bits(1, 1);
                            prior = 8;
                            for (int e = 0; e < (l < 6 ? 16 : 64); e++) begin
                                d = $urandom_range(0, 9) == 0 ? -int'(prior)
                                                              : $urandom_range(0, 255) - 128;
                                put_se(d);
                                nxt = prior + 8'(d);
                                if (nxt == 0) break;
                                prior = nxt;
                            end
                        end else begin
                            put_bits(0, 1);
                        end
                    end
                end else begin
                    put_bits(0, 1);
                end
            end
            put_ue($urandom_range(0, 12));
            poc = $urandom_range(0, 3);
            put_ue(poc == 3 ? $urandom_range(2, 40) : poc);
            if (poc == 0) put_ue($urandom_range(0, 12));
            if (poc == 1) begin
                put_bits($urandom_range(0, 1), 1);
                put_se($urandom_range(0, 2000) - 1000);
                put_se($urandom_range(0, 2000) - 1000);
                cyc = $urandom_range(0, 4);
                put_ue(cyc);
                repeat (cyc) put_se($urandom_range(0, 2000) - 1000);
            end
            put_ue($urandom_range(0, 16));
            put_bits($urandom_range(0, 1), 1);
            put_ue(pick_size());
            put_ue(pick_size());
            d = $urandom_range(0, 1);
            put_bits(d, 1);
            if (d == 0) put_bits($urandom_range(0, 1), 1);
            put_bits($urandom_range(0, 1), 1);
            if ($urandom_range(0, 1)) begin
                put_bits(1, 1);
                repeat (4) put_ue(pick_crop());
            end else begin
                put_bits(0, 1);
            end
        end
        while (sps_bits.size() % 8 != 0) sps_bits.push_back($urandom_range(0, 1));
        repeat ($urandom_range(0, 2)) put_bits($urandom_range(0, 255), 8);
        // A few units end early.
        if ($urandom_range(0, 9) == 0)
            sps_bits = sps_bits[0 : 8 * $urandom_range(1, sps_bits.size() / 8) - 1];
    endtask

    task automatic send_sps();
        int n;
        logic [7:0] b;
        t_dims none;
        none = '{16'd0, 16'd0, STATUS_OK};
        n = sps_bits.size() / 8;
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 8; j++) b[7 - j] = sps_bits[8 * k + j];
            send_byte(b, k == n - 1, 0, none);
        end
    endtask

    localparam t_dims NoDims = '{16'd0, 16'd0, STATUS_OK};
    localparam t_dims Short  = '{16'd0, 16'd0, STATUS_TRUNCATED};
    localparam t_dims LongPf = '{16'd0, 16'd0, STATUS_PREFIX};

    // Directed units: lone bytes at both extremes, a unit whose first Golomb code
    // has a 32-zero prefix, a minimal baseline unit of one macroblock and a cut copy.
    t_row directed_rows[] = '{
        '{8'h00, 1'b1, 1, Short},
        '{8'hFF, 1'b1, 1, Short},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h00, 1'b0, 0, NoDims},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h00, 1'b0, 0, NoDims},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h00, 1'b0, 0, NoDims},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h00, 1'b0, 0, NoDims},
        '{8'hFF, 1'b1, 1, LongPf},
        '{8'h67, 1'b0, 0, NoDims}, '{8'h42, 1'b0, 0, NoDims},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h1E, 1'b0, 0, NoDims},
        '{8'hDD, 1'b0, 0, NoDims}, '{8'hE0, 1'b1, 0, NoDims},
        '{8'h67, 1'b0, 0, NoDims}, '{8'h42, 1'b0, 0, NoDims},
        '{8'h00, 1'b0, 0, NoDims}, '{8'h1E, 1'b1, 1, Short}
    };

    initial begin
        walker_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[k])
            send_byte(directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].dims);
        row_typed = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_dims.size() != 0) @(negedge i_clk);
        while (bytes_sent < 1300) begin
            if (bytes_sent > 1100) quiet = 1;
            build_sps();
            send_sps();
        end
        s_axis_tvalid <= 1'b0;
        while (pending_dims.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[h264_sps_dimension_parser_top] OK");
        end else begin
            $display("[h264_sps_dimension_parser_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[h264_sps_dimension_parser_top] ERROR");
        $finish;
    end

endmodule
